// ----- design/flow_sensor_packet_receiver_unit_defines.svh -----
// Assertion macros shared by the flow sensor packet receiver modules.
// No dependencies; included by the files that carry assertions.
`ifndef FLOW_SENSOR_PACKET_RECEIVER_UNIT_DEFINES_SVH
`define FLOW_SENSOR_PACKET_RECEIVER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define FSP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fsp assertion failed");
// next-cycle implication
`define FSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fsp assertion failed");
`else
`define FSP_ASSERT_NOW(label, clk, rst, ante, cons)
`define FSP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- design/fsp_pkg.sv -----
// Package for the flow sensor packet receiver: sizes, codes, record type,
// CRC step and float-to-fixed conversion. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fsp_pkg;

  localparam int PACKET_LEN  = 23;
  localparam int WINDOW_LEN  = 20;
  localparam int FRAC_BITS   = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam int IDX_W  = $clog2(PACKET_LEN);
  localparam int WPTR_W = $clog2(WINDOW_LEN);
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CRC_POLY          = 8'hD4;
  localparam logic [7:0] CRC_MASK          = 8'h3F;
  localparam logic [7:0] EXPECTED_START_RST = 8'hF1;

  // byte positions within a packet
  localparam logic [IDX_W-1:0] POS_COUNT_HI = IDX_W'(1);
  localparam logic [IDX_W-1:0] POS_COUNT_LO = IDX_W'(2);
  localparam logic [IDX_W-1:0] POS_STATE    = IDX_W'(5);
  localparam logic [IDX_W-1:0] POS_FLOW_LO  = IDX_W'(8);
  localparam logic [IDX_W-1:0] POS_FLOW_HI  = IDX_W'(11);
  localparam logic [IDX_W-1:0] POS_BUB_LO   = IDX_W'(18);
  localparam logic [IDX_W-1:0] POS_BUB_HI   = IDX_W'(21);
  localparam logic [IDX_W-1:0] POS_CRC      = IDX_W'(PACKET_LEN - 1);

  // window sum and the averaging divide: (sum << AVG_SHIFT) / 20000 is taken
  // as (sum << 3) / 625, split at bit 20 so each reciprocal multiply stays
  // within 32 bits
  localparam int SUM_W     = 32 + $clog2(WINDOW_LEN);
  localparam int AVG_SHIFT = 16 - FRAC_BITS;
  localparam int AVG_DIV   = WINDOW_LEN * 1000;
  localparam int AVG_POW2  = 5;
  localparam int AVG_ODD   = AVG_DIV >> AVG_POW2;
  localparam int AVG_NUM_W = SUM_W + AVG_SHIFT - AVG_POW2;
  localparam int AVG_LO_W  = 20;
  localparam int AVG_HI_W  = AVG_NUM_W - AVG_LO_W;
  localparam int AVG_REM_W = $clog2(AVG_ODD);
  localparam int AVG_T_W   = AVG_REM_W + AVG_LO_W;
  localparam int AVG_RSH   = 40;
  localparam logic [31:0] AVG_RECIP = 32'd1759218605;  // ceil(2^40 / 625)
  localparam int BUB_DIV   = 10;
  localparam int BUB_RSH   = 35;
  localparam logic [31:0] BUB_RECIP = 32'hCCCC_CCCD;   // ceil(2^35 / 10)
  localparam int PROD_W    = 64;
  localparam int DIV_CYC   = 4;
  localparam int CNT_W     = $clog2(DIV_CYC);

  // divide steps
  localparam logic [CNT_W-1:0] STEP_MUL_HI  = CNT_W'(0);
  localparam logic [CNT_W-1:0] STEP_QUOT_HI = CNT_W'(1);
  localparam logic [CNT_W-1:0] STEP_REM     = CNT_W'(2);
  localparam logic [CNT_W-1:0] STEP_MUL_LO  = CNT_W'(3);

  // output field widths
  localparam int AVG_W       = 31;
  localparam int WHOLE_W     = 29;
  localparam int TENTH_W     = 4;
  localparam int M_TDATA_W   = 80;
  localparam int M_PAD_W     = M_TDATA_W - (2 + 8 + AVG_W + WHOLE_W + TENTH_W);

  // float conversion
  localparam int FIX_W      = 32;
  localparam int SIG_W      = 24;
  localparam int FLOAT_BIAS = 150 - FRAC_BITS;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_START = 2'd1,
    ST_BAD_COUNT = 2'd2,
    ST_BAD_CRC   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CONV,
    B_SUM,
    B_DIV,
    B_DONE
  } back_state_t;

  // one finished packet as handed from front to back
  typedef struct packed {
    status_t     status;
    logic [7:0]  state;
    logic [31:0] flow;
    logic [31:0] bubble;
  } pkt_rec_t;

  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] a;
    a = crc ^ b;
    return a[7] ? ({a[6:0], 1'b0} ^ CRC_POLY) : {a[6:0], 1'b0};
  endfunction

  // IEEE single to unsigned fixed point, truncating; negatives give zero,
  // overflow, +inf and NaN saturate
  function automatic logic [FIX_W-1:0] flow_to_fixed(input logic [31:0] f);
    logic              sgn;
    logic [7:0]        ex;
    logic [22:0]       man;
    logic [SIG_W-1:0]  sig;
    logic signed [9:0] sh;
    logic [9:0]        nsh;
    logic [FIX_W-1:0]  r;
    sgn = f[31];
    ex  = f[30:23];
    man = f[22:0];
    sig = {1'b1, man};
    sh  = signed'({2'b00, ex}) - signed'(10'(FLOAT_BIAS));
    nsh = 10'(-sh);
    if (ex == 8'hFF) begin
      r = ((man != 23'd0) || !sgn) ? '1 : '0;
    end else if (sgn || (ex == 8'd0)) begin
      r = '0;
    end else if (sh > signed'(10'(FIX_W - SIG_W))) begin
      r = '1;
    end else if (sh >= 10'sd0) begin
      r = FIX_W'(sig) << sh[3:0];
    end else if (nsh >= 10'(SIG_W)) begin
      r = '0;
    end else begin
      r = FIX_W'(sig) >> nsh[4:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/fsp_front.sv -----
// Byte parser: tracks position in the packet, runs the CRC, captures fields
// and hands a finished packet record to the queue. Uses fsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fsp_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [7:0]        cfg_wr_data,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [7:0]        s_tdata,
  input  wire logic              s_tuser,
  input  wire logic              q_full,
  output logic                   q_push,
  output fsp_pkg::pkt_rec_t      q_rec
);
  import fsp_pkg::*;

  logic [7:0]       expected_start;
  logic [IDX_W-1:0] byte_index;
  logic [7:0]       crc_reg;
  logic             start_ok;
  logic [15:0]      count_field;
  logic [7:0]       state_capture;
  logic [31:0]      flow_raw;
  logic [31:0]      bubble_raw;

  logic       accept;
  logic       in_packet;
  logic [1:0] flow_lane;
  logic [1:0] bub_lane;
  status_t    status;

  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;
  assign in_packet = accept && !s_tuser && (byte_index != '0);
  assign flow_lane = 2'(byte_index - POS_FLOW_LO);
  assign bub_lane  = 2'(byte_index - POS_BUB_LO);
  assign q_push    = in_packet && (byte_index == POS_CRC);

  always_comb begin
    if (!start_ok) begin
      status = ST_BAD_START;
    end else if (count_field != 16'(PACKET_LEN)) begin
      status = ST_BAD_COUNT;
    end else if (s_tdata != (crc_reg & CRC_MASK)) begin
      status = ST_BAD_CRC;
    end else begin
      status = ST_OK;
    end
  end

  assign q_rec = '{status: status, state: state_capture, flow: flow_raw,
                   bubble: bubble_raw};

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_start <= EXPECTED_START_RST;
      byte_index     <= '0;
      crc_reg        <= '0;
      start_ok       <= 1'b0;
      count_field    <= '0;
      state_capture  <= '0;
      flow_raw       <= '0;
      bubble_raw     <= '0;
    end else begin
      if (cfg_wr_en) begin
        expected_start <= cfg_wr_data;
      end
      if (accept && s_tuser) begin
        crc_reg    <= s_tdata;
        start_ok   <= (s_tdata == expected_start);
        byte_index <= IDX_W'(1);
      end else if (in_packet) begin
        if (byte_index == POS_COUNT_HI) begin
          count_field[15:8] <= s_tdata;
        end
        if (byte_index == POS_COUNT_LO) begin
          count_field[7:0] <= s_tdata;
        end
        if (byte_index == POS_STATE) begin
          state_capture <= s_tdata;
        end
        if (byte_index inside {[POS_FLOW_LO:POS_FLOW_HI]}) begin
          flow_raw[{flow_lane, 3'b000} +: 8] <= s_tdata;
        end
        if (byte_index inside {[POS_BUB_LO:POS_BUB_HI]}) begin
          bubble_raw[{bub_lane, 3'b000} +: 8] <= s_tdata;
        end
        if (byte_index == POS_CRC) begin
          byte_index <= '0;
        end else begin
          crc_reg    <= crc_step(crc_reg, s_tdata);
          byte_index <= byte_index + IDX_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/fsp_queue.sv -----
// Short FIFO of packet records between the parser and the result engine.
// Uses fsp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fsp_queue (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire fsp_pkg::pkt_rec_t push_rec,
  output logic              full,
  input  wire logic         pop,
  output fsp_pkg::pkt_rec_t head,
  output logic              empty
);
  import fsp_pkg::*;

  pkt_rec_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/fsp_back.sv -----
// Result engine: converts the flow value, updates the sliding window and
// runs the reciprocal-multiply divides for the average and the bubble digits.
// Uses fsp_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "flow_sensor_packet_receiver_unit_defines.svh"

module fsp_back (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire fsp_pkg::pkt_rec_t        q_head,
  input  wire logic                     q_empty,
  output logic                          q_pop,
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  output logic [fsp_pkg::M_TDATA_W-1:0] m_tdata
);
  import fsp_pkg::*;

  back_state_t state;
  back_state_t state_next;

  // current packet
  logic [7:0]       cur_state;
  logic [31:0]      cur_flow;
  logic [31:0]      cur_bubble;
  logic [FIX_W-1:0] sample;

  // window
  logic [FIX_W-1:0]  window [WINDOW_LEN];
  logic [SUM_W-1:0]  win_sum;
  logic [SUM_W-1:0]  win_sum_next;
  logic [WPTR_W-1:0] win_ptr;

  // dividers: high half of the average first, its remainder joins the low half
  logic [AVG_NUM_W-1:0] avg_num;
  logic [AVG_HI_W-1:0]  avg_hi;
  logic [AVG_LO_W-1:0]  avg_lo;
  logic [AVG_HI_W-1:0]  avg_hi_q;
  logic [AVG_HI_W-1:0]  avg_rh;
  logic [AVG_T_W-1:0]   avg_part;
  logic [31:0]          avg_mul_in;
  logic [PROD_W-1:0]    avg_mul;
  logic [PROD_W-1:0]    avg_p;
  logic [PROD_W-1:0]    bub_p;
  logic [WHOLE_W-1:0]   bub_q;
  logic [TENTH_W-1:0]   bub_r;
  logic [CNT_W-1:0]     div_cnt;

  // last good values and output status
  logic [7:0]         good_state;
  logic [AVG_W-1:0]   good_avg;
  logic [WHOLE_W-1:0] good_whole;
  logic [TENTH_W-1:0] good_tenth;
  status_t            out_status;

  logic    out_free;
  logic    out_load;
  logic    good_update;
  status_t load_status;

  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {M_PAD_W'(0), good_tenth, good_whole, good_avg, good_state, out_status};

  assign win_sum_next = win_sum - SUM_W'(window[win_ptr]) + SUM_W'(sample);

  assign avg_hi     = avg_num[AVG_NUM_W-1 -: AVG_HI_W];
  assign avg_lo     = avg_num[AVG_LO_W-1:0];
  assign avg_rh     = avg_hi - AVG_HI_W'(avg_hi_q * AVG_HI_W'(AVG_ODD));
  assign avg_mul_in = (div_cnt == STEP_MUL_HI) ? 32'(avg_hi) : 32'(avg_part);
  assign avg_mul    = PROD_W'(avg_mul_in) * PROD_W'(AVG_RECIP);

  always_comb begin
    state_next  = state;
    q_pop       = 1'b0;
    out_load    = 1'b0;
    good_update = 1'b0;
    load_status = q_head.status;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          if (q_head.status != ST_OK) begin
            // bad packet: report straight away with the last good values
            if (out_free) begin
              q_pop    = 1'b1;
              out_load = 1'b1;
            end
          end else begin
            q_pop      = 1'b1;
            state_next = B_CONV;
          end
        end
      end
      B_CONV: state_next = B_SUM;
      B_SUM:  state_next = B_DIV;
      B_DIV: begin
        if (div_cnt == CNT_W'(DIV_CYC - 1)) begin
          state_next = B_DONE;
        end
      end
      B_DONE: begin
        load_status = ST_OK;
        if (out_free) begin
          out_load    = 1'b1;
          good_update = 1'b1;
          state_next  = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_state  <= q_head.state;
      cur_flow   <= q_head.flow;
      cur_bubble <= q_head.bubble;
    end
    if (state == B_CONV) begin
      sample <= flow_to_fixed(cur_flow);
    end
    if (state == B_SUM) begin
      avg_num <= AVG_NUM_W'(win_sum_next) << (AVG_SHIFT - AVG_POW2);
      div_cnt <= '0;
    end else if (state == B_DIV) begin
      div_cnt <= div_cnt + CNT_W'(1);
      case (div_cnt)
        STEP_MUL_HI: begin
          avg_p <= avg_mul;
          bub_p <= PROD_W'(cur_bubble) * PROD_W'(BUB_RECIP);
        end
        STEP_QUOT_HI: begin
          avg_hi_q <= avg_p[AVG_RSH +: AVG_HI_W];
          bub_q    <= bub_p[BUB_RSH +: WHOLE_W];
        end
        STEP_REM: begin
          avg_part <= {avg_rh[AVG_REM_W-1:0], avg_lo};
          bub_r    <= TENTH_W'(cur_bubble - 32'(bub_q) * 32'(BUB_DIV));
        end
        STEP_MUL_LO: begin
          avg_p <= avg_mul;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        window[i] <= '0;
      end
      win_sum    <= '0;
      win_ptr    <= '0;
      good_state <= '0;
      good_avg   <= '0;
      good_whole <= '0;
      good_tenth <= '0;
      out_status <= ST_OK;
      m_tvalid   <= 1'b0;
    end else begin
      if (state == B_SUM) begin
        window[win_ptr] <= sample;
        win_sum         <= win_sum_next;
        win_ptr         <= (win_ptr == WPTR_W'(WINDOW_LEN - 1)) ? '0 : win_ptr + WPTR_W'(1);
      end
      if (good_update) begin
        good_state <= cur_state;
        good_avg   <= AVG_W'({avg_hi_q, avg_p[AVG_RSH +: AVG_LO_W]});
        good_whole <= bub_q;
        good_tenth <= bub_r;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (out_load) begin
        out_status <= load_status;
        m_tvalid   <= 1'b1;
      end
    end
  end

  `FSP_ASSERT_NOW(a_ptr_range, clk, rst, 1'b1, win_ptr <= WPTR_W'(WINDOW_LEN - 1))
  `FSP_ASSERT_NOW(a_pop_idle, clk, rst, q_pop, state == B_IDLE)
  `FSP_ASSERT_NOW(a_tenth_range, clk, rst, state == B_DONE, bub_r < TENTH_W'(BUB_DIV))
  `FSP_ASSERT_NOW(a_no_overwrite, clk, rst, m_tvalid && !m_tready, !out_load)
  `FSP_ASSERT_NEXT(a_good_ok, clk, rst, good_update, m_tvalid && (out_status == ST_OK))

endmodule

`default_nettype wire

// ----- design/flow_sensor_packet_receiver_unit.sv -----
// Top level of the flow sensor packet receiver: byte parser, record queue
// and result engine. Uses fsp_pkg, fsp_front, fsp_queue and fsp_back.
`timescale 1ns / 1ps
`default_nettype none

// Takes one packet byte per clock on the s_ side (tuser high marks byte 0)
// and gives one result item per 23-byte packet on the m_ side. The parser
// runs at one byte a cycle; it only stalls when the two-entry record queue
// is full, which happens only while results are held back on the m_ side.
// A bad packet's record waits in the queue until the result engine is idle
// and the m_ side is free, then is reported with the last good values. A
// good packet goes through flow conversion, the window update and the
// reciprocal-multiply divide steps. The window resets to zero together with
// the block. expected_start is written through cfg_wr_en/cfg_wr_data, and
// the user must do so only while the block is idle, which is not enforced.
module flow_sensor_packet_receiver_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wr_en,
  input  wire logic [7:0]                    cfg_wr_data,   // expected_start
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [7:0]                    s_tdata,       // rx_byte
  input  wire logic                          s_tuser,       // first_byte
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // status[1:0], sensor_state[9:2], flow_average[40:10],
  // bubble_whole[69:41], bubble_tenth[73:70], zero fill above
  output logic [fsp_pkg::M_TDATA_W-1:0]      m_tdata
);
  import fsp_pkg::*;

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  pkt_rec_t q_rec;
  pkt_rec_t q_head;

  fsp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_rec       (q_rec)
  );

  fsp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_rec (q_rec),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  fsp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_head   (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

// ----- bench/fsp_packet_checker.sv -----
// Result checker for the flow sensor packet receiver: follows the byte and
// result channels, predicts each result and compares it. Depends on fsp_pkg.
`timescale 1ns / 1ps

module fsp_packet_checker (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_wr_en,
  input  wire logic [7:0]                   cfg_wr_data,
  input  wire logic                         s_tvalid,
  input  wire logic                         s_tready,
  input  wire logic [7:0]                   s_tdata,
  input  wire logic                         s_tuser,
  input  wire logic                         m_tvalid,
  input  wire logic                         m_tready,
  input  wire logic [fsp_pkg::M_TDATA_W-1:0] m_tdata,
  output int                                mismatches,
  output int                                outstanding,
  output int                                results_seen
);

  localparam int WIN = fsp_pkg::WINDOW_LEN;

  typedef struct packed {
    fsp_pkg::status_t status;
    logic [7:0]       sensor_state;
    logic [30:0]      flow_avg;
    logic [28:0]      bub_whole;
    logic [3:0]       bub_tenth;
  } reading_t;

  logic [7:0]  start_pattern;
  int          byte_pos;
  logic [7:0]  crc_acc;
  bit          start_match;
  logic [15:0] count_word;
  logic [7:0]  state_byte;
  logic [31:0] flow_word;
  logic [31:0] bubble_word;
  logic [31:0] window [WIN];
  logic [63:0] window_total;
  int          slot;
  logic [7:0]  kept_state;
  logic [30:0] kept_avg;
  logic [31:0] kept_bubble;
  reading_t    readings_due [$];
  int          err_n;
  int          seen_n;

  initial begin
    mismatches   = 0;
    outstanding  = 0;
    results_seen = 0;
    err_n        = 0;
    seen_n       = 0;
  end

  // IEEE single (ml/min) to unsigned Q24.8, truncating; negatives give zero,
  // out-of-range, +inf and NaN saturate
  function automatic logic [31:0] flow_fixed(input logic [31:0] f);
    logic [7:0]  ex;
    logic [22:0] frac;
    logic [63:0] mant;
    int          shift;
    ex    = f[30:23];
    frac  = f[22:0];
    mant  = {40'd0, 1'b1, frac};
    shift = int'(ex) - 150 + fsp_pkg::FRAC_BITS;
    if (ex == 8'hFF) return (frac != 23'd0 || !f[31]) ? '1 : '0;
    if (f[31] || ex == 8'd0) return '0;
    if (shift > 8) return '1;
    if (shift >= 0) begin
      mant = mant << shift;
      return (mant > 64'hFFFF_FFFF) ? '1 : mant[31:0];
    end
    if (-shift >= 32) return '0;
    mant = mant >> (-shift);
    return mant[31:0];
  endfunction

  always @(posedge clk) begin : watch
    logic [7:0]  b;
    logic [7:0]  mixed;
    logic [31:0] sample;
    logic [63:0] quot;
    reading_t    want;
    reading_t    got;
    logic [5:0]  fill;
    if (rst) begin
      start_pattern = fsp_pkg::EXPECTED_START_RST;
      byte_pos      = 0;
      crc_acc       = '0;
      start_match   = 1'b0;
      count_word    = '0;
      state_byte    = '0;
      flow_word     = '0;
      bubble_word   = '0;
      for (int i = 0; i < WIN; i++) window[i] = '0;
      window_total  = '0;
      slot          = 0;
      kept_state    = '0;
      kept_avg      = '0;
      kept_bubble   = '0;
      readings_due.delete();
    end else begin
      if (cfg_wr_en) start_pattern = cfg_wr_data;

      if (s_tvalid && s_tready) begin
        b = s_tdata;
        if (s_tuser) begin
          crc_acc     = b;
          start_match = (b == start_pattern);
          byte_pos    = 1;
        end else if (byte_pos == 0 || byte_pos >= fsp_pkg::PACKET_LEN) begin
          byte_pos = 0;  // stray item between packets
        end else begin
          if (byte_pos == 1) count_word[15:8] = b;
          if (byte_pos == 2) count_word[7:0] = b;
          if (byte_pos == 5) state_byte = b;
          if (byte_pos >= 8 && byte_pos <= 11) flow_word[(byte_pos - 8) * 8 +: 8] = b;
          if (byte_pos >= 18 && byte_pos <= 21) bubble_word[(byte_pos - 18) * 8 +: 8] = b;

          if (byte_pos < fsp_pkg::PACKET_LEN - 1) begin
            mixed    = crc_acc ^ b;
            crc_acc  = mixed[7] ? ({mixed[6:0], 1'b0} ^ fsp_pkg::CRC_POLY)
                                : {mixed[6:0], 1'b0};
            byte_pos = byte_pos + 1;
          end else begin
            byte_pos = 0;
            if (!start_match)
              want.status = fsp_pkg::ST_BAD_START;
            else if (count_word != 16'(fsp_pkg::PACKET_LEN))
              want.status = fsp_pkg::ST_BAD_COUNT;
            else if (b != (crc_acc & fsp_pkg::CRC_MASK))
              want.status = fsp_pkg::ST_BAD_CRC;
            else
              want.status = fsp_pkg::ST_OK;

            if (want.status == fsp_pkg::ST_OK) begin
              sample       = flow_fixed(flow_word);
              window_total = window_total - window[slot] + sample;
              window[slot] = sample;
              slot         = (slot + 1) % WIN;
              quot         = (window_total << (16 - fsp_pkg::FRAC_BITS)) / (WIN * 1000);
              kept_avg     = quot[30:0];
              kept_state   = state_byte;
              kept_bubble  = bubble_word;
            end
            want.sensor_state = kept_state;
            want.flow_avg     = kept_avg;
            want.bub_whole    = 29'(kept_bubble / 10);
            want.bub_tenth    = 4'(kept_bubble % 10);
            readings_due.push_back(want);
          end
        end
      end

      if (m_tvalid && m_tready) begin
        got.status       = fsp_pkg::status_t'(m_tdata[1:0]);
        got.sensor_state = m_tdata[9:2];
        got.flow_avg     = m_tdata[40:10];
        got.bub_whole    = m_tdata[69:41];
        got.bub_tenth    = m_tdata[73:70];
        fill             = m_tdata[fsp_pkg::M_TDATA_W-1:74];
        seen_n           = seen_n + 1;
        if (readings_due.size() == 0) begin
          err_n = err_n + 1;
          $display("%0t: result item with none expected: status %0d state %h avg %0d",
                   $time, got.status, got.sensor_state, got.flow_avg);
        end else begin
          want = readings_due.pop_front();
          if (got !== want || fill !== '0) begin
            err_n = err_n + 1;
            $display("%0t: expected status %0d state %h avg %0d whole %0d tenth %0d",
                     $time, want.status, want.sensor_state, want.flow_avg,
                     want.bub_whole, want.bub_tenth);
            $display("%0t:   actual status %0d state %h avg %0d whole %0d tenth %0d fill %h",
                     $time, got.status, got.sensor_state, got.flow_avg,
                     got.bub_whole, got.bub_tenth, fill);
          end
        end
      end
    end
    mismatches   <= err_n;
    outstanding  <= readings_due.size();
    results_seen <= seen_n;
  end

endmodule

// ----- bench/testbench.sv -----
// Top of the flow sensor packet receiver bench: clock, reset, packet and
// noise stimulus, start pattern changes and the verdict. Uses fsp_pkg,
// fsp_packet_checker and flow_sensor_packet_receiver_unit.
`timescale 1ns / 1ps

module testbench;

  import fsp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_BYTES = 230;
  localparam int SETTLE      = 40;

  typedef enum int {PK_GOOD, PK_BAD_START, PK_BAD_COUNT, PK_BAD_CRC} pkt_kind_t;

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 cfg_wr_en   = 1'b0;
  logic [7:0]           cfg_wr_data = 8'd0;
  logic                 s_tvalid    = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata     = 8'd0;
  logic                 s_tuser     = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready    = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  bit         steady        = 1'b0;
  logic [7:0] start_now     = EXPECTED_START_RST;
  int         cycle_count   = 0;
  int         bytes_sent    = 0;
  int         packets_sent  = 0;
  int         patterns_used = 1;
  int         phase_bytes   = 0;
  int         mismatches;
  int         outstanding;
  int         results_seen;

  initial forever #1 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  always @(negedge clk) m_tready <= steady || ($urandom_range(99) >= 10);

  flow_sensor_packet_receiver_unit uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  fsp_packet_checker watcher (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timed out after %0d cycles with %0d results outstanding",
             cycle_count, outstanding);
    $display("Verification failed");
    $finish;
  end

  // called and returns at a falling edge
  task automatic push_byte(input logic [7:0] b, input bit first);
    while (!steady && $urandom_range(99) < 10) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= first;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  // flow values biased towards plausible rates, with the conversion corners
  function automatic logic [31:0] pick_flow();
    logic [31:0] f;
    f = $urandom();
    case ($urandom_range(9))
      0: ;
      1: begin
        case ($urandom_range(9))
          0: f = 32'h0000_0000;
          1: f = 32'h8000_0000;
          2: f = 32'h7F80_0000;
          3: f = 32'hFF80_0000;
          4: f = {f[31], 8'hFF, f[22:1], 1'b1};
          5: f = {9'd0, f[22:0]};
          6: f = 32'h7F7F_FFFF;
          7: f = {1'b0, 8'd150, f[22:0]};
          8: f = {1'b0, 8'd151, f[22:0]};
          default: f = {1'b0, 8'(110 + f[31]), f[22:0]};
        endcase
      end
      2: f = {1'b0, 8'($urandom_range(160, 145)), f[22:0]};
      3: f = {1'b1, 8'($urandom_range(254, 1)), f[22:0]};
      default: f = {1'b0, 8'($urandom_range(148, 112)), f[22:0]};
    endcase
    return f;
  endfunction

  // builds a packet of the given kind and sends its first upto bytes
  task automatic send_packet(input pkt_kind_t kind, input int upto);
    logic [7:0]  p [PACKET_LEN];
    logic [7:0]  crc;
    logic [7:0]  mixed;
    logic [15:0] cnt;
    logic [31:0] flow;
    logic [31:0] bub;
    for (int i = 0; i < PACKET_LEN; i++) p[i] = 8'($urandom_range(255));
    p[0] = start_now;
    if (kind == PK_BAD_START)
      while (p[0] == start_now) p[0] = 8'($urandom_range(255));

    cnt = 16'(PACKET_LEN);
    if (kind == PK_BAD_COUNT || (kind == PK_BAD_START && $urandom_range(1))) begin
      case ($urandom_range(3))
        0: cnt = 16'h1700;
        1: cnt = 16'h0117;
        2: cnt = 16'd22;
        default: cnt = 16'($urandom());
      endcase
      if (cnt == 16'(PACKET_LEN)) cnt = 16'd24;
    end
    p[1] = cnt[15:8];
    p[2] = cnt[7:0];

    flow = pick_flow();
    for (int i = 0; i < 4; i++) p[8 + i] = flow[i * 8 +: 8];
    case ($urandom_range(7))
      0: bub = 32'd0;
      1: bub = 32'hFFFF_FFFF;
      default: bub = $urandom();
    endcase
    for (int i = 0; i < 4; i++) p[18 + i] = bub[i * 8 +: 8];

    crc = p[0];
    for (int i = 1; i < PACKET_LEN - 1; i++) begin
      mixed = crc ^ p[i];
      crc   = mixed[7] ? ({mixed[6:0], 1'b0} ^ CRC_POLY) : {mixed[6:0], 1'b0};
    end
    p[PACKET_LEN-1] = crc & CRC_MASK;
    // a single flipped bit, upper two included, must fail the check
    if (kind == PK_BAD_CRC || (kind != PK_GOOD && $urandom_range(1)))
      p[PACKET_LEN-1] = p[PACKET_LEN-1] ^ 8'(1 << $urandom_range(7));

    for (int i = 0; i < upto; i++) push_byte(p[i], i == 0);
    if (upto == PACKET_LEN) packets_sent++;
    phase_bytes += upto;
  endtask

  task automatic run_phase();
    int pick;
    phase_bytes = 0;
    send_packet(PK_GOOD, PACKET_LEN);
    while (phase_bytes < PHASE_BYTES) begin
      pick = $urandom_range(99);
      if (pick < 60)
        send_packet(PK_GOOD, PACKET_LEN);
      else if (pick < 68)
        send_packet(PK_BAD_START, PACKET_LEN);
      else if (pick < 76)
        send_packet(PK_BAD_COUNT, PACKET_LEN);
      else if (pick < 84)
        send_packet(PK_BAD_CRC, PACKET_LEN);
      else if (pick < 92)
        send_packet(PK_GOOD, $urandom_range(PACKET_LEN - 1, 1));
      else
        repeat ($urandom_range(3, 1)) push_byte(8'($urandom_range(255)), 1'b0);
    end
    s_tvalid <= 1'b0;
  endtask

  // hold the sender until all results are in, let the back end settle,
  // then change the start pattern
  task automatic set_start(input logic [7:0] v);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    start_now   = v;
    patterns_used++;
  endtask

  initial begin
    logic [7:0] patterns [5];
    patterns[0] = 8'hF0;
    patterns[1] = 8'h00;
    patterns[2] = 8'hFF;
    patterns[3] = 8'($urandom_range(255));
    patterns[4] = EXPECTED_START_RST;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // stray items while idle, then a dropped start and a restart
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    send_packet(PK_GOOD, PACKET_LEN);

    run_phase();
    for (int k = 0; k < 5; k++) begin
      set_start(patterns[k]);
      steady = (k == 2);
      run_phase();
    end
    steady = 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d bytes (%0d whole packets) under %0d start patterns;",
             bytes_sent, packets_sent, patterns_used);
    $display("checked %0d results in %0d cycles, %0d mismatches.",
             results_seen, cycle_count, mismatches);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
